@@ hw/rtl/pn3d_pkg.sv @@
// Package for the 3D gradient noise unit: permutation table, gradient and fade helpers.
// Depends on nothing; used by all pn3d modules and the top level.
`default_nettype none
package pn3d_pkg;

  localparam int unsigned TW = 17;  // fraction offset width, 0..65535 plus sign room
  localparam int unsigned DW = 20;  // corner dot product width, |d| <= 2*65536
  localparam int unsigned VW = 20;  // blended value width
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [15:0] HALF_Q16 = 16'd32768;

  typedef logic [7:0] perm_t;

  function automatic perm_t perm_at(input logic [7:0] idx);
    perm_t r;
    case (idx)
      8'd0: r = 8'd151; 8'd1: r = 8'd160; 8'd2: r = 8'd137; 8'd3: r = 8'd91;
      8'd4: r = 8'd90; 8'd5: r = 8'd15; 8'd6: r = 8'd131; 8'd7: r = 8'd13;
      8'd8: r = 8'd201; 8'd9: r = 8'd95; 8'd10: r = 8'd96; 8'd11: r = 8'd53;
      8'd12: r = 8'd194; 8'd13: r = 8'd233; 8'd14: r = 8'd7; 8'd15: r = 8'd225;
      8'd16: r = 8'd140; 8'd17: r = 8'd36; 8'd18: r = 8'd103; 8'd19: r = 8'd30;
      8'd20: r = 8'd69; 8'd21: r = 8'd142; 8'd22: r = 8'd8; 8'd23: r = 8'd99;
      8'd24: r = 8'd37; 8'd25: r = 8'd240; 8'd26: r = 8'd21; 8'd27: r = 8'd10;
      8'd28: r = 8'd23; 8'd29: r = 8'd190; 8'd30: r = 8'd6; 8'd31: r = 8'd148;
      8'd32: r = 8'd247; 8'd33: r = 8'd120; 8'd34: r = 8'd234; 8'd35: r = 8'd75;
      8'd36: r = 8'd0; 8'd37: r = 8'd26; 8'd38: r = 8'd197; 8'd39: r = 8'd62;
      8'd40: r = 8'd94; 8'd41: r = 8'd252; 8'd42: r = 8'd219; 8'd43: r = 8'd203;
      8'd44: r = 8'd117; 8'd45: r = 8'd35; 8'd46: r = 8'd11; 8'd47: r = 8'd32;
      8'd48: r = 8'd57; 8'd49: r = 8'd177; 8'd50: r = 8'd33; 8'd51: r = 8'd88;
      8'd52: r = 8'd237; 8'd53: r = 8'd149; 8'd54: r = 8'd56; 8'd55: r = 8'd87;
      8'd56: r = 8'd174; 8'd57: r = 8'd20; 8'd58: r = 8'd125; 8'd59: r = 8'd136;
      8'd60: r = 8'd171; 8'd61: r = 8'd168; 8'd62: r = 8'd68; 8'd63: r = 8'd175;
      8'd64: r = 8'd74; 8'd65: r = 8'd165; 8'd66: r = 8'd71; 8'd67: r = 8'd134;
      8'd68: r = 8'd139; 8'd69: r = 8'd48; 8'd70: r = 8'd27; 8'd71: r = 8'd166;
      8'd72: r = 8'd77; 8'd73: r = 8'd146; 8'd74: r = 8'd158; 8'd75: r = 8'd231;
      8'd76: r = 8'd83; 8'd77: r = 8'd111; 8'd78: r = 8'd229; 8'd79: r = 8'd122;
      8'd80: r = 8'd60; 8'd81: r = 8'd211; 8'd82: r = 8'd133; 8'd83: r = 8'd230;
      8'd84: r = 8'd220; 8'd85: r = 8'd105; 8'd86: r = 8'd92; 8'd87: r = 8'd41;
      8'd88: r = 8'd55; 8'd89: r = 8'd46; 8'd90: r = 8'd245; 8'd91: r = 8'd40;
      8'd92: r = 8'd244; 8'd93: r = 8'd102; 8'd94: r = 8'd143; 8'd95: r = 8'd54;
      8'd96: r = 8'd65; 8'd97: r = 8'd25; 8'd98: r = 8'd63; 8'd99: r = 8'd161;
      8'd100: r = 8'd1; 8'd101: r = 8'd216; 8'd102: r = 8'd80; 8'd103: r = 8'd73;
      8'd104: r = 8'd209; 8'd105: r = 8'd76; 8'd106: r = 8'd132; 8'd107: r = 8'd187;
      8'd108: r = 8'd208; 8'd109: r = 8'd89; 8'd110: r = 8'd18; 8'd111: r = 8'd169;
      8'd112: r = 8'd200; 8'd113: r = 8'd196; 8'd114: r = 8'd135; 8'd115: r = 8'd130;
      8'd116: r = 8'd116; 8'd117: r = 8'd188; 8'd118: r = 8'd159; 8'd119: r = 8'd86;
      8'd120: r = 8'd164; 8'd121: r = 8'd100; 8'd122: r = 8'd109; 8'd123: r = 8'd198;
      8'd124: r = 8'd173; 8'd125: r = 8'd186; 8'd126: r = 8'd3; 8'd127: r = 8'd64;
      8'd128: r = 8'd52; 8'd129: r = 8'd217; 8'd130: r = 8'd226; 8'd131: r = 8'd250;
      8'd132: r = 8'd124; 8'd133: r = 8'd123; 8'd134: r = 8'd5; 8'd135: r = 8'd202;
      8'd136: r = 8'd38; 8'd137: r = 8'd147; 8'd138: r = 8'd118; 8'd139: r = 8'd126;
      8'd140: r = 8'd255; 8'd141: r = 8'd82; 8'd142: r = 8'd85; 8'd143: r = 8'd212;
      8'd144: r = 8'd207; 8'd145: r = 8'd206; 8'd146: r = 8'd59; 8'd147: r = 8'd227;
      8'd148: r = 8'd47; 8'd149: r = 8'd16; 8'd150: r = 8'd58; 8'd151: r = 8'd17;
      8'd152: r = 8'd182; 8'd153: r = 8'd189; 8'd154: r = 8'd28; 8'd155: r = 8'd42;
      8'd156: r = 8'd223; 8'd157: r = 8'd183; 8'd158: r = 8'd170; 8'd159: r = 8'd213;
      8'd160: r = 8'd119; 8'd161: r = 8'd248; 8'd162: r = 8'd152; 8'd163: r = 8'd2;
      8'd164: r = 8'd44; 8'd165: r = 8'd154; 8'd166: r = 8'd163; 8'd167: r = 8'd70;
      8'd168: r = 8'd221; 8'd169: r = 8'd153; 8'd170: r = 8'd101; 8'd171: r = 8'd155;
      8'd172: r = 8'd167; 8'd173: r = 8'd43; 8'd174: r = 8'd172; 8'd175: r = 8'd9;
      8'd176: r = 8'd129; 8'd177: r = 8'd22; 8'd178: r = 8'd39; 8'd179: r = 8'd253;
      8'd180: r = 8'd19; 8'd181: r = 8'd98; 8'd182: r = 8'd108; 8'd183: r = 8'd110;
      8'd184: r = 8'd79; 8'd185: r = 8'd113; 8'd186: r = 8'd224; 8'd187: r = 8'd232;
      8'd188: r = 8'd178; 8'd189: r = 8'd185; 8'd190: r = 8'd112; 8'd191: r = 8'd104;
      8'd192: r = 8'd218; 8'd193: r = 8'd246; 8'd194: r = 8'd97; 8'd195: r = 8'd228;
      8'd196: r = 8'd251; 8'd197: r = 8'd34; 8'd198: r = 8'd242; 8'd199: r = 8'd193;
      8'd200: r = 8'd238; 8'd201: r = 8'd210; 8'd202: r = 8'd144; 8'd203: r = 8'd12;
      8'd204: r = 8'd191; 8'd205: r = 8'd179; 8'd206: r = 8'd162; 8'd207: r = 8'd241;
      8'd208: r = 8'd81; 8'd209: r = 8'd51; 8'd210: r = 8'd145; 8'd211: r = 8'd235;
      8'd212: r = 8'd249; 8'd213: r = 8'd14; 8'd214: r = 8'd239; 8'd215: r = 8'd107;
      8'd216: r = 8'd49; 8'd217: r = 8'd192; 8'd218: r = 8'd214; 8'd219: r = 8'd31;
      8'd220: r = 8'd181; 8'd221: r = 8'd199; 8'd222: r = 8'd106; 8'd223: r = 8'd157;
      8'd224: r = 8'd184; 8'd225: r = 8'd84; 8'd226: r = 8'd204; 8'd227: r = 8'd176;
      8'd228: r = 8'd115; 8'd229: r = 8'd121; 8'd230: r = 8'd50; 8'd231: r = 8'd45;
      8'd232: r = 8'd127; 8'd233: r = 8'd4; 8'd234: r = 8'd150; 8'd235: r = 8'd254;
      8'd236: r = 8'd138; 8'd237: r = 8'd236; 8'd238: r = 8'd205; 8'd239: r = 8'd93;
      8'd240: r = 8'd222; 8'd241: r = 8'd114; 8'd242: r = 8'd67; 8'd243: r = 8'd29;
      8'd244: r = 8'd24; 8'd245: r = 8'd72; 8'd246: r = 8'd243; 8'd247: r = 8'd141;
      8'd248: r = 8'd128; 8'd249: r = 8'd195; 8'd250: r = 8'd78; 8'd251: r = 8'd66;
      8'd252: r = 8'd215; 8'd253: r = 8'd61; 8'd254: r = 8'd156; 8'd255: r = 8'd180;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // Dot product of gradient h with the corner offset; offsets are signed 18-bit.
  function automatic logic signed [DW-1:0] grad_dot(input logic [3:0] h,
      input logic signed [17:0] dx, input logic signed [17:0] dy,
      input logic signed [17:0] dz);
    logic signed [DW-1:0] u;
    logic signed [DW-1:0] v;
    logic sel_x;
    logic sel_y;
    sel_x = (h < 4'd8) || (h == 4'd12) || (h == 4'd13);
    sel_y = (h < 4'd4) || (h == 4'd12) || (h == 4'd13);
    u = sel_x ? DW'(dx) : DW'(dy);
    v = sel_y ? DW'(dy) : DW'(dz);
    if (h[0]) u = -u;
    if (h[1]) v = -v;
    return u + v;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/perlin_noise_3d_unit.sv @@
// Top level of the pipelined 3D improved gradient noise unit.
// Depends on pn3d_pkg, pn3d_fade and pn3d_lerp.
//
//  channel | signals                                   | direction
//  in      | in_valid/in_ready, coord_x/y/z_i          | sink
//  out     | out_valid/out_ready, noise_value_o        | source
//
// One beat enters per cycle while the pipeline is not stalled; beats pass through stages S1..S7.
// S1 splits coords, S2-S3 hash through the permutation table, S4 forms the
// corner dot products, S5-S7 blend along x, y, z. The fade curves run in parallel.
// The whole pipeline advances together; it stalls only when the last stage
// holds a beat that the sink does not take. Reset clears the valid bits.
`default_nettype none
module perlin_noise_3d_unit #(
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] coord_x_i,
  input  wire logic [31:0] coord_y_i,
  input  wire logic [31:0] coord_z_i,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [18:0]      noise_value_o
);
  import pn3d_pkg::*;

  localparam int unsigned NS = 7;

  logic [NS-1:0] vld_q;
  logic          adv;

  assign adv      = !vld_q[NS-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS-2:0], in_valid};
    end
  end

  // Split into cell and Q0.16 fraction.
  function automatic logic [15:0] frac16(input logic [31:0] c);
    logic [COORD_FRAC_BITS+15:0] f;
    f = (COORD_FRAC_BITS+16)'(c[COORD_FRAC_BITS-1:0]) << 16;
    return 16'(f >> COORD_FRAC_BITS);
  endfunction

  // S1: cells and fractions.
  logic [7:0]  cx1_q, cy1_q, cz1_q;
  logic [15:0] tx1_q, ty1_q, tz1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cx1_q <= coord_x_i[COORD_FRAC_BITS +: 8];
      cy1_q <= coord_y_i[COORD_FRAC_BITS +: 8];
      cz1_q <= coord_z_i[COORD_FRAC_BITS +: 8];
      tx1_q <= frac16(coord_x_i);
      ty1_q <= frac16(coord_y_i);
      tz1_q <= frac16(coord_z_i);
    end
  end

  // S2: first two hash levels for the four x/y corner pairs.
  logic [7:0]  hxy2_q [4];
  logic [7:0]  cz2_q;
  logic [15:0] tx2_q, ty2_q, tz2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        hxy2_q[i] <= perm_at(perm_at(cx1_q + 8'(i >> 1)) + cy1_q + 8'(i & 1));
      end
      cz2_q <= cz1_q;
      tx2_q <= tx1_q; ty2_q <= ty1_q; tz2_q <= tz1_q;
    end
  end

  // S3: final hash per corner.
  logic [3:0]  h3_q [8];
  logic [15:0] tx3_q, ty3_q, tz3_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 8; i++) begin
        h3_q[i] <= 4'(perm_at(hxy2_q[i >> 1] + cz2_q + 8'(i & 1)));
      end
      tx3_q <= tx2_q; ty3_q <= ty2_q; tz3_q <= tz2_q;
    end
  end

  // S4: gradient dot products.
  logic signed [VW-1:0] d4_q [8];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 8; i++) begin
        d4_q[i] <= VW'(grad_dot(h3_q[i],
          18'({2'b00, tx3_q}) - ((i & 4) != 0 ? 18'(ONE_Q16) : 18'd0),
          18'({2'b00, ty3_q}) - ((i & 2) != 0 ? 18'(ONE_Q16) : 18'd0),
          18'({2'b00, tz3_q}) - ((i & 1) != 0 ? 18'(ONE_Q16) : 18'd0)));
      end
    end
  end

  // Fade curves: inputs enter from S1 so w appears aligned with S3 outputs.
  logic [16:0] fx, fy, fz;
  pn3d_fade u_fx (.clk_i, .en_i(adv), .t_i(tx1_q), .w_o(fx));
  pn3d_fade u_fy (.clk_i, .en_i(adv), .t_i(ty1_q), .w_o(fy));
  pn3d_fade u_fz (.clk_i, .en_i(adv), .t_i(tz1_q), .w_o(fz));

  // Fade results are valid after two stages (S3); hold them to their lerp stage.
  logic [16:0] fx4_q, fy4_q, fy5_q, fz4_q, fz5_q, fz6_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      fx4_q <= fx; fy4_q <= fy; fz4_q <= fz;
      fy5_q <= fy4_q; fz5_q <= fz4_q; fz6_q <= fz5_q;
    end
  end

  // S5: blend along x.
  logic signed [VW-1:0] x5 [4];
  for (genvar g = 0; g < 4; g++) begin : g_lx
    pn3d_lerp u_l (.clk_i, .en_i(adv), .w_i(fx4_q), .a_i(d4_q[g]), .b_i(d4_q[g+4]),
                   .r_o(x5[g]));
  end
  // S6: blend along y.
  logic signed [VW-1:0] y6 [2];
  for (genvar g = 0; g < 2; g++) begin : g_ly
    pn3d_lerp u_l (.clk_i, .en_i(adv), .w_i(fy5_q), .a_i(x5[g]), .b_i(x5[g+2]),
                   .r_o(y6[g]));
  end
  // S7: blend along z.
  logic signed [VW-1:0] r7;
  pn3d_lerp u_lz (.clk_i, .en_i(adv), .w_i(fz6_q), .a_i(y6[0]), .b_i(y6[1]), .r_o(r7));

  assign noise_value_o = r7[18:0];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(noise_value_o))
    else $error("result lost on stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready) else $error("pipeline stalled without cause");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> vld_q[0]) else $error("accepted beat not tracked");
endmodule
`default_nettype wire

@@ hw/rtl/pn3d_fade.sv @@
// Two-stage pipelined fade curve 6t^5-15t^4+10t^3 in Q0.16.
// Depends on pn3d_pkg. Advances when en_i is high.
`default_nettype none
module pn3d_fade (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [15:0] t_i,
  output logic      [16:0] w_o
);
  import pn3d_pkg::*;

  logic [15:0] t1_q;
  logic [16:0] sq_q;
  logic [16:0] cu_q;
  logic [19:0] poly_q;
  logic [33:0] sq_full;
  logic [33:0] cu_full;
  logic [19:0] poly_d;
  logic [37:0] w_full;
  logic [21:0] w_sh;

  // t*t rounds to at most 65535, kept 17 bits for safety.
  assign sq_full = 34'(t_i) * 34'(t_i) + 34'(HALF_Q16);
  assign cu_full = 34'(sq_q) * 34'(t1_q) + 34'(HALF_Q16);
  // q = 6*t2 + 655360 - 15*t, always positive and below 2^20.
  assign poly_d = 20'(20'(sq_q) * 20'd6 + 20'd655360 - 20'(t1_q) * 20'd15);
  assign w_full = 38'(cu_q) * 38'(poly_q) + 38'(HALF_Q16);
  assign w_sh = w_full[37:16];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q   <= t_i;
      sq_q   <= sq_full[32:16];
      cu_q   <= cu_full[32:16];
      poly_q <= poly_d;
    end
  end

  // Final product registered by the caller through w_o's consumer stage.
  assign w_o = (w_sh > 22'(ONE_Q16)) ? ONE_Q16 : w_sh[16:0];
endmodule
`default_nettype wire

@@ hw/rtl/pn3d_lerp.sv @@
// One registered lerp lane: a + round_half_up(w*(b-a) / 2^16).
// Depends on pn3d_pkg. Advances when en_i is high.
`default_nettype none
module pn3d_lerp (
  input  wire logic                               clk_i,
  input  wire logic                               en_i,
  input  wire logic [16:0]                        w_i,
  input  wire logic signed [pn3d_pkg::VW-1:0]     a_i,
  input  wire logic signed [pn3d_pkg::VW-1:0]     b_i,
  output logic signed [pn3d_pkg::VW-1:0]          r_o
);
  import pn3d_pkg::*;

  logic signed [VW:0]    diff;
  logic signed [VW+18:0] prod;
  logic signed [VW+18:0] rnd;

  assign diff = (VW+1)'(b_i) - (VW+1)'(a_i);
  assign prod = (VW+19)'(signed'({1'b0, w_i})) * (VW+19)'(diff);
  assign rnd  = (prod + (VW+19)'(HALF_Q16)) >>> 16;

  always_ff @(posedge clk_i) begin
    if (en_i) r_o <= a_i + VW'(rnd);
  end
endmodule
`default_nettype wire
